// File: sv/tmh_pkg.sv
// Shared types, status codes and ordering function for the timer deadline heap.
package tmh_pkg;

  localparam int unsigned IdW = 12;
  localparam int unsigned DeadlineW = 64;
  localparam int unsigned LeewayW = 32;
  localparam int unsigned StatusW = 3;
  localparam int unsigned CmdW = 2;

  localparam logic [CmdW-1:0] CMD_INSERT = 2'd0;
  localparam logic [CmdW-1:0] CMD_POP = 2'd1;
  localparam logic [CmdW-1:0] CMD_REMOVE = 2'd2;
  localparam logic [CmdW-1:0] CMD_UNUSED = 2'd3;

  localparam logic [StatusW-1:0] ST_OK = 3'd0;
  localparam logic [StatusW-1:0] ST_EMPTY = 3'd1;
  localparam logic [StatusW-1:0] ST_FULL = 3'd2;
  localparam logic [StatusW-1:0] ST_NOT_QUEUED = 3'd3;
  localparam logic [StatusW-1:0] ST_QUEUED = 3'd4;

  typedef struct packed {
    logic [IdW-1:0]       id;
    logic [DeadlineW-1:0] deadline;
    logic [LeewayW-1:0]   leeway;
  } entry_t;

  localparam int unsigned EntryW = IdW + DeadlineW + LeewayW;

  // True when entry a must sit above entry b in the heap.
  function automatic logic earlier(entry_t a, entry_t b);
    if (a.deadline != b.deadline) begin
      return a.deadline < b.deadline;
    end
    return a.leeway < b.leeway;
  endfunction

endpackage

// File: sv/tmh_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module tmh_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/timer_deadline_min_heap.sv
// Timer deadline queue: binary min-heap of timers held in synchronous memories.
//
// The input channel (valid/stall) carries one command item: insert a timer,
// remove the earliest timer, or remove a given timer id. The output channel
// returns exactly one result item per command: a status code and, for a
// successful removal, the removed timer's id, deadline and leeway.
// The block works on one item at a time; stall is high while an item is at
// work. Items are ordered by deadline, then by smaller leeway.
// Steps per item: an error answer goes straight from the check to the result.
// An insert climbs from the new slot, one parent read and compare per level;
// a removal reads the target slot and the last slot, moves the last entry into
// the gap, climbs if it beats its parent, else sinks, one level per left read,
// right read and compare (two child reads through the one heap read port).
// An unused command code is answered with ST_OK and no timer.
// After reset the id position table is swept clear, one id per cycle, over all
// ID_COUNT ids (4096 by default); stall stays high during that sweep.
// A finished result waits in the output register while the receiver stalls;
// the next item is only taken once that result has been loaded.
module timer_deadline_min_heap #(
  parameter int unsigned CAPACITY = 4096,
  parameter int unsigned ID_COUNT = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  command,
  input  logic [11:0] event_id,
  input  logic [63:0] deadline,
  input  logic [31:0] leeway,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [11:0] out_id,
  output logic [63:0] out_deadline,
  output logic [31:0] out_leeway
);

  localparam int unsigned PW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned XW = CW + 1;
  localparam int unsigned IW = $clog2(ID_COUNT);
  localparam int unsigned EW = tmh_pkg::EntryW;

  typedef enum logic [12:0] {
    S_CLEAR = 13'b0000000000001,
    S_IDLE  = 13'b0000000000010,
    S_CHECK = 13'b0000000000100,
    S_TREAD = 13'b0000000001000,
    S_TGOT  = 13'b0000000010000,
    S_TLAST = 13'b0000000100000,
    S_UREAD = 13'b0000001000000,
    S_UCMP  = 13'b0000010000000,
    S_DLEFT = 13'b0000100000000,
    S_DRGHT = 13'b0001000000000,
    S_DCMP  = 13'b0010000000000,
    S_WBACK = 13'b0100000000000,
    S_DONE  = 13'b1000000000000
  } state_t;

  state_t state, state_next;

  logic [1:0]      cmd_r;
  logic [11:0]     id_r;
  logic [63:0]     dl_r;
  logic [31:0]     lw_r;
  logic [CW-1:0]   cnt;
  tmh_pkg::entry_t cur;
  tmh_pkg::entry_t lft;
  logic [PW-1:0]   curpos;
  logic [PW-1:0]   tpos;
  logic            moved;
  logic            take_mode;
  logic            rgt_ok;
  logic [2:0]      res_status;
  tmh_pkg::entry_t res;
  logic [IW:0]     clr;

  // Heap memory and id position memory ports.
  logic            h_we;
  logic [PW-1:0]   h_waddr, h_raddr;
  tmh_pkg::entry_t h_wdata, h_rdata;
  logic [EW-1:0]   h_rbits;
  logic            p_we;
  logic [IW-1:0]   p_waddr, p_raddr;
  logic [PW:0]     p_wdata, p_rdata;

  tmh_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_heap_ram (
    .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
    .raddr(h_raddr), .rdata(h_rbits)
  );
  assign h_rdata = tmh_pkg::entry_t'(h_rbits);

  tmh_ram #(.WIDTH(PW + 1), .DEPTH(ID_COUNT)) u_pos_ram (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
    .raddr(p_raddr), .rdata(p_rdata)
  );

  logic [16:0]   r_id_x;
  logic          r_id_ok;
  logic [IW-1:0] r_id_idx;
  logic [XW-1:0] left_x, right_x;
  logic [PW-1:0] parent;
  logic [CW-1:0] cnt_dec;
  logic          pos_q;
  logic [PW-1:0] pos_p;
  logic          up_win;
  logic          l_win;
  logic          r_win;
  logic          accept;

  assign r_id_x   = 17'(id_r);
  assign r_id_ok  = r_id_x < 17'(ID_COUNT);
  assign r_id_idx = r_id_x[IW-1:0];
  assign left_x   = XW'({curpos, 1'b1});
  assign right_x  = left_x + XW'(1);
  assign parent   = (curpos - PW'(1)) >> 1;
  assign cnt_dec  = cnt - CW'(1);
  assign pos_q    = p_rdata[PW];
  assign pos_p    = p_rdata[PW-1:0];
  assign up_win   = tmh_pkg::earlier(cur, h_rdata);
  assign l_win    = tmh_pkg::earlier(lft, cur);
  assign r_win    = rgt_ok && tmh_pkg::earlier(h_rdata, l_win ? lft : cur);
  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;

  function automatic logic [IW-1:0] id_index(logic [11:0] id);
    logic [16:0] x;
    x = 17'(id);
    return x[IW-1:0];
  endfunction

  // Memory address and write selection.
  always_comb begin
    h_we    = 1'b0;
    h_waddr = curpos;
    h_wdata = cur;
    h_raddr = tpos;
    p_we    = 1'b0;
    p_waddr = id_index(cur.id);
    p_wdata = {1'b1, curpos};
    p_raddr = id_index(event_id);
    case (state)
      S_CLEAR: begin
        p_we    = 1'b1;
        p_waddr = clr[IW-1:0];
        p_wdata = '0;
      end
      S_TREAD: h_raddr = tpos;
      S_TGOT: begin
        h_raddr = cnt_dec[PW-1:0];
        p_we    = 1'b1;
        p_waddr = id_index(h_rdata.id);
        p_wdata = '0;
      end
      S_UREAD: h_raddr = parent;
      S_UCMP: begin
        if (up_win) begin
          h_we    = 1'b1;
          h_wdata = h_rdata;
          p_we    = 1'b1;
          p_waddr = id_index(h_rdata.id);
        end
      end
      S_DLEFT: h_raddr = left_x[PW-1:0];
      S_DRGHT: h_raddr = right_x[PW-1:0];
      S_DCMP: begin
        if (l_win || r_win) begin
          h_we    = 1'b1;
          h_wdata = r_win ? h_rdata : lft;
          p_we    = 1'b1;
          p_waddr = id_index(r_win ? h_rdata.id : lft.id);
        end
      end
      S_WBACK: begin
        h_we = 1'b1;
        p_we = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: if (clr == (IW + 1)'(ID_COUNT - 1)) state_next = S_IDLE;
      S_IDLE:  if (accept) state_next = S_CHECK;
      S_CHECK: begin
        state_next = S_DONE;
        if (cmd_r == tmh_pkg::CMD_INSERT) begin
          if (r_id_ok && !pos_q && (cnt < CW'(CAPACITY))) state_next = S_UREAD;
        end else if (cmd_r == tmh_pkg::CMD_POP) begin
          if (cnt != '0) state_next = S_TREAD;
        end else if (cmd_r == tmh_pkg::CMD_REMOVE) begin
          if (r_id_ok && pos_q && (CW'(pos_p) < cnt)) state_next = S_TREAD;
        end
      end
      S_TREAD: state_next = S_TGOT;
      S_TGOT:  state_next = (CW'(tpos) < cnt_dec) ? S_TLAST : S_DONE;
      S_TLAST: state_next = S_UREAD;
      S_UREAD: begin
        if (curpos != '0) state_next = S_UCMP;
        else state_next = (take_mode && !moved) ? S_DLEFT : S_WBACK;
      end
      S_UCMP: begin
        if (up_win) state_next = S_UREAD;
        else state_next = (take_mode && !moved) ? S_DLEFT : S_WBACK;
      end
      S_DLEFT: state_next = (left_x < XW'(cnt)) ? S_DRGHT : S_WBACK;
      S_DRGHT: state_next = S_DCMP;
      S_DCMP:  state_next = (l_win || r_win) ? S_DLEFT : S_WBACK;
      S_WBACK: state_next = S_DONE;
      S_DONE:  if (!out_valid || !out_stall) state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr       <= '0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr <= clr + (IW + 1)'(1);
      end
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (state == S_DONE && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end
      if (state == S_CHECK && state_next == S_UREAD) begin
        cnt <= cnt + CW'(1);
      end
      if (state == S_TGOT) begin
        cnt <= cnt_dec;
      end
    end
  end

  // Datapath registers; their values only matter inside an item's work.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= command;
      id_r  <= event_id;
      dl_r  <= deadline;
      lw_r  <= leeway;
    end
    case (state)
      S_CHECK: begin
        res        <= '0;
        res_status <= tmh_pkg::ST_OK;
        moved      <= 1'b0;
        take_mode  <= 1'b1;
        tpos       <= '0;
        if (cmd_r == tmh_pkg::CMD_INSERT) begin
          take_mode <= 1'b0;
          cur       <= '{id: id_r, deadline: dl_r, leeway: lw_r};
          curpos    <= cnt[PW-1:0];
          if (!r_id_ok) res_status <= tmh_pkg::ST_NOT_QUEUED;
          else if (pos_q) res_status <= tmh_pkg::ST_QUEUED;
          else if (cnt >= CW'(CAPACITY)) res_status <= tmh_pkg::ST_FULL;
        end else if (cmd_r == tmh_pkg::CMD_POP) begin
          if (cnt == '0) res_status <= tmh_pkg::ST_EMPTY;
        end else if (cmd_r == tmh_pkg::CMD_REMOVE) begin
          tpos <= pos_p;
          if (!r_id_ok || !pos_q || (CW'(pos_p) >= cnt)) begin
            res_status <= tmh_pkg::ST_NOT_QUEUED;
          end
        end
      end
      S_TGOT: res <= h_rdata;
      S_TLAST: begin
        cur    <= h_rdata;
        curpos <= tpos;
      end
      S_UCMP: begin
        if (up_win) begin
          curpos <= parent;
          moved  <= 1'b1;
        end
      end
      S_DRGHT: begin
        lft    <= h_rdata;
        rgt_ok <= right_x < XW'(cnt);
      end
      S_DCMP: begin
        if (r_win) curpos <= right_x[PW-1:0];
        else if (l_win) curpos <= left_x[PW-1:0];
      end
      default: ;
    endcase
    if (state == S_DONE && (!out_valid || !out_stall)) begin
      status       <= res_status;
      out_id       <= res.id;
      out_deadline <= res.deadline;
      out_leeway   <= res.leeway;
    end
  end

endmodule

// File: sv/tmh_checker.sv
// Port-level checker for the timer deadline heap, bound to the top level.
module tmh_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  status,
  input logic [11:0] out_id,
  input logic [63:0] out_deadline,
  input logic [31:0] out_leeway
);

  // A result item carries a defined status code.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == tmh_pkg::ST_OK || status == tmh_pkg::ST_EMPTY ||
                   status == tmh_pkg::ST_FULL || status == tmh_pkg::ST_NOT_QUEUED ||
                   status == tmh_pkg::ST_QUEUED))
    else $error("undefined status code");

  // An error answer never reports a timer.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != tmh_pkg::ST_OK) |->
      (out_id == '0 && out_deadline == '0 && out_leeway == '0))
    else $error("error result carries timer fields");

  // One item is worked at a time: an accepted item makes the block busy.
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("item accepted while another is at work");

  // A stalled result holds.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(status) && $stable(out_id)))
    else $error("stalled result changed");

endmodule

bind timer_deadline_min_heap tmh_checker u_tmh_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .status(status),
  .out_id(out_id), .out_deadline(out_deadline), .out_leeway(out_leeway)
);

// File: test/tb_top.sv
// Self-checking testbench for the timer deadline min-heap queue.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned Depth = 4096;
  localparam int unsigned IdCount = 4096;

  typedef struct packed {
    logic [tmh_pkg::StatusW-1:0]   status;
    logic [tmh_pkg::IdW-1:0]       id;
    logic [tmh_pkg::DeadlineW-1:0] deadline;
    logic [tmh_pkg::LeewayW-1:0]   leeway;
  } answer_t;

  typedef struct {
    logic [tmh_pkg::CmdW-1:0]      cmd;
    logic [tmh_pkg::IdW-1:0]       id;
    logic [tmh_pkg::DeadlineW-1:0] deadline;
    logic [tmh_pkg::LeewayW-1:0]   leeway;
    bit                            typed;
    logic [tmh_pkg::StatusW-1:0]   want_status;
  } row_t;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic [1:0] command;
  logic [11:0] event_id;
  logic [63:0] deadline;
  logic [31:0] leeway;
  logic out_valid;
  logic out_stall;
  logic [2:0] status;
  logic [11:0] out_id;
  logic [63:0] out_deadline;
  logic [31:0] out_leeway;

  timer_deadline_min_heap dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .command(command), .event_id(event_id), .deadline(deadline), .leeway(leeway),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .out_id(out_id), .out_deadline(out_deadline), .out_leeway(out_leeway)
  );

  // Predictor copy of the heap.
  tmh_pkg::entry_t heap_slot [Depth];
  int unsigned heap_pos [IdCount];
  bit heap_queued [IdCount];
  int unsigned heap_count;

  answer_t pending_answers[$];
  int unsigned mismatches;
  int unsigned answers_seen;
  int unsigned pops_ok;
  int unsigned removes_ok;
  int unsigned errors_seen;
  int unsigned peak_count;
  bit hold_receiver;
  bit done_sending;
  row_t rows[$];

  function automatic bit goes_above(int unsigned a, int unsigned b);
    if (heap_slot[a].deadline != heap_slot[b].deadline) begin
      return heap_slot[a].deadline < heap_slot[b].deadline;
    end
    return heap_slot[a].leeway < heap_slot[b].leeway;
  endfunction

  function automatic void swap_slots(int unsigned a, int unsigned b);
    tmh_pkg::entry_t t;
    t = heap_slot[a];
    heap_slot[a] = heap_slot[b];
    heap_slot[b] = t;
    heap_pos[heap_slot[a].id] = a;
    heap_pos[heap_slot[b].id] = b;
  endfunction

  function automatic void sift_up(int unsigned i);
    int unsigned up;
    while (i != 0) begin
      up = (i - 1) / 2;
      if (!goes_above(i, up)) break;
      swap_slots(i, up);
      i = up;
    end
  endfunction

  function automatic void sift_down(int unsigned i);
    int unsigned l;
    int unsigned best;
    forever begin
      l = 2 * i + 1;
      best = i;
      if (l >= heap_count) break;
      if (goes_above(l, best)) best = l;
      if (l + 1 < heap_count && goes_above(l + 1, best)) best = l + 1;
      if (best == i) break;
      swap_slots(i, best);
      i = best;
    end
  endfunction

  function automatic answer_t extract_slot(int unsigned p);
    answer_t a;
    a.status = tmh_pkg::ST_OK;
    a.id = heap_slot[p].id;
    a.deadline = heap_slot[p].deadline;
    a.leeway = heap_slot[p].leeway;
    heap_queued[heap_slot[p].id] = 1'b0;
    heap_count--;
    if (p < heap_count) begin
      heap_slot[p] = heap_slot[heap_count];
      heap_pos[heap_slot[p].id] = p;
      if (p != 0 && goes_above(p, (p - 1) / 2)) sift_up(p);
      else sift_down(p);
    end
    return a;
  endfunction

  function automatic answer_t predict_queue(logic [1:0] c, logic [11:0] id,
                                            logic [63:0] dl, logic [31:0] lw);
    answer_t a;
    a = '0;
    a.status = tmh_pkg::ST_OK;
    if (c == tmh_pkg::CMD_INSERT) begin
      if (id >= IdCount) a.status = tmh_pkg::ST_NOT_QUEUED;
      else if (heap_queued[id]) a.status = tmh_pkg::ST_QUEUED;
      else if (heap_count >= Depth) a.status = tmh_pkg::ST_FULL;
      else begin
        heap_slot[heap_count] = '{id: id, deadline: dl, leeway: lw};
        heap_pos[id] = heap_count;
        heap_queued[id] = 1'b1;
        heap_count++;
        sift_up(heap_count - 1);
        if (heap_count > peak_count) peak_count = heap_count;
      end
    end else if (c == tmh_pkg::CMD_POP) begin
      if (heap_count == 0) a.status = tmh_pkg::ST_EMPTY;
      else a = extract_slot(0);
    end else if (c == tmh_pkg::CMD_REMOVE) begin
      if (id >= IdCount || !heap_queued[id] || heap_pos[id] >= heap_count) begin
        a.status = tmh_pkg::ST_NOT_QUEUED;
      end else begin
        a = extract_slot(heap_pos[id]);
      end
    end
    return a;
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #400ms;
    $display("status: fail");
    $finish;
  end

  // Result checker.
  always @(posedge clk) begin
    answer_t want;
    if (!rst && out_valid && !out_stall) begin
      answers_seen++;
      if (pending_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result status=%0d id=%0d", status, out_id);
      end else begin
        want = pending_answers.pop_front();
        if (status != want.status || out_id != want.id || out_deadline != want.deadline
            || out_leeway != want.leeway) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: want st=%0d id=%0d dl=%h lw=%h, got st=%0d id=%0d dl=%h lw=%h",
                     want.status, want.id, want.deadline, want.leeway,
                     status, out_id, out_deadline, out_leeway);
          end
        end
        if (want.status == tmh_pkg::ST_OK && want.id != 0) removes_ok++;
        if (want.status != tmh_pkg::ST_OK) errors_seen++;
      end
    end
  end

  // Receiver stall pattern, with one long hold-off on request.
  initial begin
    int unsigned mode;
    out_stall = 1'b1;
    @(negedge clk);
    forever begin
      @(negedge clk);
      if (hold_receiver) out_stall <= 1'b1;
      else begin
        mode = $urandom_range(0, 3);
        if (mode == 0) out_stall <= 1'b0;
        else if (mode == 1) out_stall <= ($urandom_range(0, 3) == 0);
        else out_stall <= $urandom_range(0, 1);
      end
    end
  end

  // Receiver hold-off counted in its own process.
  initial begin
    hold_receiver = 1'b0;
    wait (done_sending == 1'b0 && rows.size() > 0);
    repeat (4096 + 3000) @(posedge clk);
    hold_receiver = 1'b1;
    repeat (1500) @(posedge clk);
    hold_receiver = 1'b0;
  end

  task automatic send_item(logic [1:0] c, logic [11:0] id, logic [63:0] dl, logic [31:0] lw,
                           bit typed, logic [2:0] want_status);
    answer_t a;
    command <= c;
    event_id <= id;
    deadline <= dl;
    leeway <= lw;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    a = predict_queue(c, id, dl, lw);
    if (typed && a.status != want_status) begin
      mismatches++;
      if (mismatches <= 10) $display("table row status: want %0d, predictor %0d",
                                     want_status, a.status);
    end
    if (c == tmh_pkg::CMD_POP && a.status == tmh_pkg::ST_OK) pops_ok++;
    pending_answers.push_back(a);
    @(negedge clk);
  endtask

  task automatic idle_gap();
    int unsigned g;
    in_valid <= 1'b0;
    g = $urandom_range(1, 6);
    repeat (g) @(negedge clk);
  endtask

  function automatic logic [11:0] pick_id(bit queued_one);
    logic [11:0] r;
    int unsigned p;
    if (queued_one && heap_count > 0) begin
      p = $urandom_range(0, heap_count - 1);
      return heap_slot[p].id;
    end
    // A small id pool makes duplicates and repeat removals common.
    r = ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'($urandom_range(0, 63));
    return r;
  endfunction

  function automatic logic [63:0] pick_deadline();
    int unsigned m;
    m = $urandom_range(0, 5);
    if (m == 0) return 64'hFFFF_FFFF_FFFF_FFFF;
    if (m == 1) return 64'd0;
    if (m == 2) return 64'($urandom_range(0, 7));
    return {$urandom, $urandom};
  endfunction

  function automatic logic [31:0] pick_leeway();
    int unsigned m;
    m = $urandom_range(0, 3);
    if (m == 0) return $urandom_range(0, 3);
    if (m == 1) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  task automatic add_row(logic [1:0] c, logic [11:0] id, logic [63:0] dl, logic [31:0] lw,
                         bit typed, logic [2:0] st);
    row_t r;
    r = '{cmd: c, id: id, deadline: dl, leeway: lw, typed: typed, want_status: st};
    rows.push_back(r);
  endtask

  initial begin
    int unsigned burst;
    int unsigned rnd;
    int unsigned sel;
    int unsigned limit;
    logic [1:0] c;
    logic [11:0] id;
    rst = 1'b1;
    in_valid = 1'b0;
    command = tmh_pkg::CMD_INSERT;
    event_id = '0;
    deadline = '0;
    leeway = '0;
    done_sending = 1'b0;
    heap_count = 0;
    peak_count = 0;
    mismatches = 0;
    answers_seen = 0;
    pops_ok = 0;
    removes_ok = 0;
    errors_seen = 0;
    for (int i = 0; i < IdCount; i++) begin
      heap_queued[i] = 1'b0;
      heap_pos[i] = 0;
    end
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed table: empty, not queued, extremes, ties, duplicates, unused command.
    add_row(tmh_pkg::CMD_POP, 12'd0, 64'd0, 32'd0, 1, tmh_pkg::ST_EMPTY);
    add_row(tmh_pkg::CMD_REMOVE, 12'd5, 64'd0, 32'd0, 1, tmh_pkg::ST_NOT_QUEUED);
    add_row(tmh_pkg::CMD_REMOVE, 12'hFFF, 64'd0, 32'd0, 1, tmh_pkg::ST_NOT_QUEUED);
    add_row(tmh_pkg::CMD_UNUSED, 12'hFFF, '1, '1, 1, tmh_pkg::ST_OK);
    add_row(tmh_pkg::CMD_INSERT, 12'hFFF, '1, '1, 1, tmh_pkg::ST_OK);
    add_row(tmh_pkg::CMD_INSERT, 12'hFFF, 64'd1, 32'd1, 1, tmh_pkg::ST_QUEUED);
    add_row(tmh_pkg::CMD_INSERT, 12'd0, 64'd0, 32'd0, 1, tmh_pkg::ST_OK);
    add_row(tmh_pkg::CMD_INSERT, 12'd1, 64'd100, 32'd7, 1, tmh_pkg::ST_OK);
    add_row(tmh_pkg::CMD_INSERT, 12'd2, 64'd100, 32'd3, 1, tmh_pkg::ST_OK);
    add_row(tmh_pkg::CMD_INSERT, 12'd3, 64'd100, 32'd3, 1, tmh_pkg::ST_OK);
    add_row(tmh_pkg::CMD_INSERT, 12'd4, 64'h8000_0000_0000_0000, 32'h8000_0000, 1,
            tmh_pkg::ST_OK);
    add_row(tmh_pkg::CMD_INSERT, 12'd5, 64'd50, 32'hFFFF_FFFF, 1, tmh_pkg::ST_OK);
    add_row(tmh_pkg::CMD_REMOVE, 12'd2, 64'd0, 32'd0, 0, tmh_pkg::ST_OK);
    add_row(tmh_pkg::CMD_REMOVE, 12'd2, 64'd0, 32'd0, 1, tmh_pkg::ST_NOT_QUEUED);
    add_row(tmh_pkg::CMD_POP, 12'd0, 64'd0, 32'd0, 0, tmh_pkg::ST_OK);
    add_row(tmh_pkg::CMD_POP, 12'd0, 64'd0, 32'd0, 0, tmh_pkg::ST_OK);
    add_row(tmh_pkg::CMD_REMOVE, 12'hFFF, 64'd0, 32'd0, 0, tmh_pkg::ST_OK);
    add_row(tmh_pkg::CMD_POP, 12'd0, 64'd0, 32'd0, 0, tmh_pkg::ST_OK);
    add_row(tmh_pkg::CMD_POP, 12'd0, 64'd0, 32'd0, 0, tmh_pkg::ST_OK);
    add_row(tmh_pkg::CMD_POP, 12'd0, 64'd0, 32'd0, 0, tmh_pkg::ST_OK);
    add_row(tmh_pkg::CMD_POP, 12'd0, 64'd0, 32'd0, 1, tmh_pkg::ST_EMPTY);
    foreach (rows[i]) begin
      send_item(rows[i].cmd, rows[i].id, rows[i].deadline, rows[i].leeway,
                rows[i].typed, rows[i].want_status);
      if ($urandom_range(0, 2) == 0) idle_gap();
    end

    // Random part in bursts; weights shift so the heap grows and shrinks.
    rnd = 0;
    while (rnd < 830) begin
      burst = $urandom_range(1, 20);
      limit = (rnd % 300 < 150) ? 65 : 35;
      for (int k = 0; k < burst; k++) begin
        sel = $urandom_range(0, 99);
        if (sel < limit) begin
          c = tmh_pkg::CMD_INSERT;
          id = pick_id(($urandom_range(0, 9) == 0));
        end else if (sel < 80) begin
          c = tmh_pkg::CMD_POP;
          id = 12'($urandom);
        end else if (sel < 97) begin
          c = tmh_pkg::CMD_REMOVE;
          id = pick_id(($urandom_range(0, 3) != 0));
        end else begin
          c = tmh_pkg::CMD_UNUSED;
          id = 12'($urandom);
        end
        send_item(c, id, pick_deadline(), pick_leeway(), 0, tmh_pkg::ST_OK);
        rnd++;
      end
      if (rnd > 400 && rnd < 430) begin
        // Pause until everything sent so far has come back.
        in_valid <= 1'b0;
        wait (pending_answers.size() == 0);
        @(negedge clk);
      end else begin
        idle_gap();
      end
    end
    in_valid <= 1'b0;
    done_sending = 1'b1;

    fork
      wait (pending_answers.size() == 0);
      begin
        repeat (200000) @(posedge clk);
      end
    join_any
    disable fork;
    repeat (50) @(posedge clk);
    $display("covered %0d results: %0d pops, %0d removals, %0d error answers, peak depth %0d",
             answers_seen, pops_ok, removes_ok, errors_seen, peak_count);
    if (mismatches == 0 && pending_answers.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, pending_answers.size());
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/tmh_pkg.sv
sv/tmh_ram.sv
sv/timer_deadline_min_heap.sv
sv/tmh_checker.sv
test/tb_top.sv
